/* sv/mhbf_pkg.sv */
// shared types and constants for the mipmap halving box filter
`default_nettype none
package mhbf_pkg;

  localparam int unsigned COMP_W   = 16;
  localparam int unsigned N_PORTS  = 4;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned NC_W     = 3;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned IDX_W    = 3;
  localparam logic [COMP_W-1:0] NARROW_MASK = 16'd255;
  localparam logic [COMP_W-1:0] WIDE_MASK   = 16'd65535;

  typedef enum logic [IDX_W-1:0] {
    REG_START_COL_ODD = 3'd0,
    REG_START_ROW_ODD = 3'd1,
    REG_SRC_WIDTH     = 3'd2,
    REG_SRC_HEIGHT    = 3'd3,
    REG_NUM_COMPS     = 3'd4,
    REG_WIDE_SAMPLES  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic       accept;
    logic       xodd;
    logic       col_zero;
    logic       fwd;
    logic       wr_en;
    logic       add_store;
    logic [1:0] shift;
  } lane_ctrl_t;

endpackage
`default_nettype wire

/* sv/mhbf_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module mhbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* sv/mhbf_lane.sv */
// one component lane: horizontal pair, line store and block average
`default_nettype none
module mhbf_lane #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned DEPTH = 2049,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mhbf_pkg::lane_ctrl_t   s0_ctrl_i,
  input  wire mhbf_pkg::lane_ctrl_t   s1_ctrl_i,
  input  wire logic [AW-1:0]          rd_addr_i,
  input  wire logic [AW-1:0]          wr_addr_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic [mhbf_pkg::COMP_W-1:0] avg_o
);
  import mhbf_pkg::*;

  localparam int unsigned HW = SAMPLE_BITS + 1;
  localparam int unsigned SW = SAMPLE_BITS + 2;
  localparam int unsigned VW = SAMPLE_BITS + 3;

  logic [SAMPLE_BITS-1:0] hp_q;
  logic [HW-1:0]          hsum;
  logic [HW-1:0]          hsum_q;
  logic                   fwd_q;
  logic [SW-1:0]          fwd_data_q;
  logic [SW-1:0]          wr_data;
  logic [SW-1:0]          rd_data;
  logic [SW-1:0]          store;
  logic [VW-1:0]          vsum;
  logic [VW-1:0]          vshift;

  always_comb begin
    if (!s0_ctrl_i.xodd || s0_ctrl_i.col_zero) begin
      hsum = HW'(sample_i);
    end else begin
      hsum = HW'(sample_i) + HW'(hp_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q  <= '0;
      fwd_q <= 1'b0;
    end else if (s0_ctrl_i.accept) begin
      if (!s0_ctrl_i.xodd) begin
        hp_q <= sample_i;
      end
      fwd_q <= s0_ctrl_i.fwd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ctrl_i.accept) begin
      hsum_q     <= hsum;
      fwd_data_q <= wr_data;
    end
  end

  assign wr_data = SW'(hsum_q);

  mhbf_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_ctrl_i.wr_en),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data),
    .re_i    (s0_ctrl_i.accept),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_data)
  );

  // bypass a write made in the same cycle as this read
  assign store  = fwd_q ? fwd_data_q : rd_data;
  assign vsum   = VW'(hsum_q) + (s1_ctrl_i.add_store ? VW'(store) : VW'(0));
  assign vshift = vsum >> s1_ctrl_i.shift;
  assign avg_o  = COMP_W'(vshift);

endmodule
`default_nettype wire

/* sv/mipmap_halve_box_filter.sv */
// top level of the 2x2 box filter mipmap downsampler
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata = comp0..comp3
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata = out_comp0..3, tlast = frame_last
//  cfg       in   cfg_we_i                     cfg_idx_i, cfg_data_i
//
// one source pixel per cycle unless a held output stalls stage 1; a request enters stage 0
// (counters, horizontal pair, line store read), stage 1 writes the line store or forms the
// average, then the output register.
// each lane does one line store read and at most one line store write per pixel.
// reset clears counters, horizontal partials and valid flags; line stores are not cleared.
// a held output stalls stage 1 only when it also has a result to deliver.
`default_nettype none
module mipmap_halve_box_filter #(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned MAX_COMPS   = 4,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [mhbf_pkg::IDX_W-1:0] cfg_idx_i,
  input  wire logic [mhbf_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // comp0, comp1, comp2, comp3
  input  wire logic [63:0]              s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // out_comp0, out_comp1, out_comp2, out_comp3
  output logic [63:0]                   m_axis_tdata,
  output logic                          m_axis_tlast
);
  import mhbf_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH / 2 + 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             sco_q, sro_q, wide_q;
  logic [DIM_W-1:0] width_q, height_q;
  logic [NC_W-1:0]  nc_q;
  logic [DIM_W-1:0] col_q, row_q;

  logic [DIM_W-1:0] w_eff, h_eff, c_eff, r_eff, c_inc, r_inc;
  logic [DIM_W-1:0] d_raw;
  logic [AW-1:0]    rd_addr;
  logic [NC_W-1:0]  nc;
  logic [COMP_W-1:0] mask;
  logic xodd, yodd, last_c, last_r, act, wr0, em0, add0;
  logic accept;

  logic          s1_valid_q, s1_wr_q, s1_em_q, s1_last_q, s1_add_q;
  logic [1:0]    s1_shift_q;
  logic [AW-1:0] s1_addr_q;
  logic          s1_fire;

  logic        m_valid_q, m_last_q;
  logic [63:0] m_data_q;

  lane_ctrl_t s0_ctrl, s1_ctrl;
  logic [COMP_W-1:0] avg [N_PORTS];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sco_q    <= 1'b0;
      sro_q    <= 1'b0;
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      nc_q     <= NC_W'(4);
      wide_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_COL_ODD: sco_q    <= cfg_data_i[0];
        REG_START_ROW_ODD: sro_q    <= cfg_data_i[0];
        REG_SRC_WIDTH:     width_q  <= cfg_data_i[DIM_W-1:0];
        REG_SRC_HEIGHT:    height_q <= cfg_data_i[DIM_W-1:0];
        REG_NUM_COMPS:     nc_q     <= cfg_data_i[NC_W-1:0];
        REG_WIDE_SAMPLES:  wide_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage 0 position decode
  always_comb begin
    w_eff = (width_q == '0) ? DIM_W'(1) : width_q;
    if (32'(w_eff) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end
    h_eff = (height_q == '0) ? DIM_W'(1) : height_q;
    c_eff = (col_q >= w_eff) ? w_eff - DIM_W'(1) : col_q;
    r_eff = (row_q >= h_eff) ? h_eff - DIM_W'(1) : row_q;
    xodd   = sco_q ^ c_eff[0];
    yodd   = sro_q ^ r_eff[0];
    last_c = (c_eff == w_eff - DIM_W'(1));
    last_r = (r_eff == h_eff - DIM_W'(1));
    d_raw  = DIM_W'(({1'b0, c_eff} + (DIM_W+1)'(sco_q)) >> 1);
    if (32'(d_raw) >= DEPTH - 1) begin
      d_raw = DIM_W'(DEPTH - 1);
    end
    rd_addr = AW'(d_raw);
    act  = xodd || last_c;
    wr0  = act && !yodd && !last_r;
    em0  = act && (yodd || last_r);
    add0 = yodd && (r_eff != '0);
    c_inc = c_eff + DIM_W'(1);
    r_inc = r_eff + DIM_W'(1);
    nc   = (32'(nc_q) > MAX_COMPS) ? NC_W'(MAX_COMPS) : nc_q;
    mask = wide_q ? (WIDE_MASK >> (COMP_W - SAMPLE_BITS)) : NARROW_MASK;
  end

  assign s1_fire       = s1_valid_q && (!s1_em_q || !m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s0_ctrl.accept    = accept;
    s0_ctrl.xodd      = xodd;
    s0_ctrl.col_zero  = (c_eff == '0);
    s0_ctrl.fwd       = s1_valid_q && s1_wr_q && (s1_addr_q == rd_addr);
    s0_ctrl.wr_en     = wr0;
    s0_ctrl.add_store = add0;
    s0_ctrl.shift     = 2'(xodd && (c_eff != '0)) + 2'(add0);
    s1_ctrl           = '0;
    s1_ctrl.wr_en     = s1_valid_q && s1_wr_q && s1_fire;
    s1_ctrl.add_store = s1_add_q;
    s1_ctrl.shift     = s1_shift_q;
  end

  // raster counters and stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_wr_q    <= 1'b0;
      s1_em_q    <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_add_q   <= 1'b0;
      s1_shift_q <= '0;
      s1_addr_q  <= '0;
    end else begin
      if (accept) begin
        if (c_inc >= w_eff) begin
          col_q <= '0;
          row_q <= (r_inc >= h_eff) ? '0 : r_inc;
        end else begin
          col_q <= c_inc;
          row_q <= r_eff;
        end
        s1_valid_q <= 1'b1;
        s1_wr_q    <= wr0;
        s1_em_q    <= em0;
        s1_last_q  <= last_c && last_r;
        s1_add_q   <= add0;
        s1_shift_q <= s0_ctrl.shift;
        s1_addr_q  <= rd_addr;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < N_PORTS; k++) begin : g_lane
    if (k < MAX_COMPS) begin : g_on
      logic [SAMPLE_BITS-1:0] sample;
      logic [COMP_W-1:0]      raw;
      assign raw    = s_axis_tdata[k*COMP_W +: COMP_W] & mask;
      assign sample = (NC_W'(k) < nc) ? SAMPLE_BITS'(raw) : '0;
      mhbf_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DEPTH       (DEPTH)
      ) u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .s0_ctrl_i (s0_ctrl),
        .s1_ctrl_i (s1_ctrl),
        .rd_addr_i (rd_addr),
        .wr_addr_i (s1_addr_q),
        .sample_i  (sample),
        .avg_o     (avg[k])
      );
    end else begin : g_off
      assign avg[k] = '0;
    end
  end

  // merge lanes into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_fire && s1_em_q) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_em_q) begin
      for (int k = 0; k < N_PORTS; k++) begin
        m_data_q[k*COMP_W +: COMP_W] <= (NC_W'(k) < nc) ? avg[k] : '0;
      end
      m_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  a_wr_xor_em : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !(s1_wr_q && s1_em_q))
    else $error("stage 1 both writes and emits");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |-> !(s1_fire && s1_em_q))
    else $error("held output overwritten");

  a_fwd_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s0_ctrl.fwd) |-> s1_ctrl.wr_en)
    else $error("bypass without a line store write");

  a_accept_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_valid_q) |-> s1_fire)
    else $error("stage 1 overrun");

endmodule
`default_nettype wire
